@@ rtl/core/bidq_pkg.sv @@
package bidq_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FLUSH  = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_SPAN   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  localparam logic [2:0] ADDR_LIMIT = 3'd0;
  localparam logic [6:0] LIMIT_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  key;
    logic [15:0] id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [3:0]  gap;
    logic [15:0] out_id;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic fl_start;
    logic fl_step;
  } cmd_t;

  typedef struct packed {
    logic go_flush;
    logic fl_last;
    logic slot_free;
  } sts_t;

endpackage

@@ rtl/core/bidq_ram.sv @@
module bidq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bidq_ctrl.sv @@
module bidq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bidq_pkg::sts_t sts,
  output bidq_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.go_flush) begin
          cmd.fl_start = 1'b1;
          state_nxt    = S_FLUSH;
        end else if (sts.slot_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (sts.slot_free) begin
          cmd.fl_step = 1'b1;
          if (sts.fl_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/bidq_dp.sv @@
module bidq_dp #(
  parameter int CAPACITY    = 64,
  parameter int NUM_BUCKETS = 13,
  parameter int KEY_BASE    = 18,
  parameter int ID_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bidq_pkg::in_item_t  in_data,
  input  bidq_pkg::cmd_t      cmd,
  output bidq_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output bidq_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  output logic [6:0]          limit_q
);

  localparam int PW = $clog2(CAPACITY);
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (ID_BITS < 16) ? ID_BITS : 16;

  logic [1:0]    kind_r;
  logic [BW-1:0] b_r;
  logic          kvalid_r;
  logic [SW-1:0] id_r;
  logic [PW-1:0] laddr_r, laddr_nxt;
  logic [CW-1:0] rem_r;
  logic [PW-1:0] free_head_r;
  logic [CW-1:0] total_r;
  logic [6:0]    limit_r;
  logic [PW-1:0] heads_r  [NUM_BUCKETS];
  logic [PW-1:0] tails_r  [NUM_BUCKETS];
  logic [CW-1:0] counts_r [NUM_BUCKETS];
  logic [CAPACITY-1:0] lvalid_r;
  logic          out_valid_r;
  bidq_pkg::out_item_t out_data_r, res;

  logic [8:0]    kd;
  logic          in_kvalid;
  logic [BW-1:0] in_b;
  logic [PW-1:0] link_ram_q, link_q, ids_waddr;
  logic [SW-1:0] ids_q;
  logic          link_we, ids_we;
  logic [PW-1:0] link_waddr, link_wdata;
  logic [6:0]    lim_eff;
  logic          full, do_insert, cnt_nz;
  logic [NUM_BUCKETS-1:0] occ;
  logic [BW-1:0] lo, hi;

  assign kd        = {1'b0, in_data.key} - 9'(KEY_BASE);
  assign in_kvalid = !kd[8] && (kd < 9'(NUM_BUCKETS));
  assign in_b      = kd[BW-1:0];

  assign lim_eff   = (limit_r < 7'(CAPACITY)) ? limit_r : 7'(CAPACITY);
  assign full      = 7'(total_r) >= lim_eff;
  assign cnt_nz    = counts_r[b_r] != '0;
  assign do_insert = cmd.exec && (kind_r == bidq_pkg::KIND_INSERT) && kvalid_r && !full;

  assign link_q = lvalid_r[laddr_r] ? link_ram_q :
                  (laddr_r == PW'(CAPACITY - 1)) ? '0 : laddr_r + 1'b1;

  always_comb begin
    laddr_nxt = laddr_r;
    if (cmd.accept) begin
      laddr_nxt = (in_data.kind == bidq_pkg::KIND_INSERT) ? free_head_r : heads_r[in_b];
    end else if (cmd.fl_step) begin
      laddr_nxt = link_q;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      occ[i] = counts_r[i] != '0;
    end
    lo = '0;
    hi = '0;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (occ[i]) lo = BW'(i);
    end
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (occ[i]) hi = BW'(i);
    end
  end

  always_comb begin
    res      = '0;
    res.last = 1'b1;
    if (kind_r == bidq_pkg::KIND_SPAN) begin
      if (occ == '0) res.status = bidq_pkg::ST_EMPTY;
      else           res.gap    = 4'(hi - lo);
    end else if (!kvalid_r) begin
      res.status = bidq_pkg::ST_RANGE;
    end else if (kind_r == bidq_pkg::KIND_INSERT) begin
      if (full) res.status = bidq_pkg::ST_FULL;
    end else if (kind_r == bidq_pkg::KIND_SEARCH) begin
      res.found = cnt_nz;
    end
  end

  // link store: insert chains the old tail, a flush step returns the node to the free list
  assign link_we    = (do_insert && cnt_nz) || cmd.fl_step;
  assign link_waddr = cmd.fl_step ? laddr_r : tails_r[b_r];
  assign link_wdata = cmd.fl_step ? free_head_r : free_head_r;
  assign ids_we     = do_insert;
  assign ids_waddr  = free_head_r;

  bidq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (laddr_nxt),
    .rdata (link_ram_q)
  );

  bidq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_ids (
    .clk   (clk),
    .we    (ids_we),
    .waddr (ids_waddr),
    .wdata (id_r),
    .raddr (laddr_nxt),
    .rdata (ids_q)
  );

  always_ff @(posedge clk) begin
    laddr_r <= laddr_nxt;
    if (cmd.accept) begin
      kind_r   <= in_data.kind;
      b_r      <= in_b;
      kvalid_r <= in_kvalid;
      id_r     <= in_data.id[SW-1:0];
    end
    if (cmd.fl_start) begin
      rem_r <= counts_r[b_r];
    end else if (cmd.fl_step) begin
      rem_r <= rem_r - 1'b1;
    end
    if (do_insert) begin
      if (!cnt_nz) heads_r[b_r] <= free_head_r;
      tails_r[b_r] <= free_head_r;
    end
    if (cmd.exec) begin
      out_data_r <= res;
    end else if (cmd.fl_step) begin
      out_data_r        <= '0;
      out_data_r.found  <= 1'b1;
      out_data_r.out_id <= 16'(ids_q);
      out_data_r.last   <= rem_r == CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      total_r     <= '0;
      limit_r     <= bidq_pkg::LIMIT_RESET;
      lvalid_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (link_we) lvalid_r[link_waddr] <= 1'b1;
      if (do_insert) begin
        free_head_r     <= link_q;
        counts_r[b_r]   <= counts_r[b_r] + 1'b1;
        total_r         <= total_r + 1'b1;
      end else if (cmd.fl_step) begin
        free_head_r <= laddr_r;
        if (rem_r == CW'(1)) begin
          counts_r[b_r] <= '0;
          total_r <= (total_r >= counts_r[b_r]) ? total_r - counts_r[b_r] : '0;
        end
      end
      if (cmd.exec || cmd.fl_step) out_valid_r <= 1'b1;
      else if (out_ready)          out_valid_r <= 1'b0;
    end
  end

  assign sts.go_flush  = (kind_r == bidq_pkg::KIND_FLUSH) && kvalid_r && cnt_nz;
  assign sts.fl_last   = rem_r == CW'(1);
  assign sts.slot_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign limit_q       = limit_r;

endmodule

@@ rtl/core/bucketed_id_queues_unit.sv @@
// Bucketed ID queues: IDs are kept in NUM_BUCKETS FIFO buckets (key KEY_BASE + b)
// sharing one linked store of CAPACITY entries. Insert, search and span pass the
// transfer cycle and an execute step in which the registered read of the link store
// lands, and the result is registered in that execute step. A flush of n IDs takes
// the transfer cycle, a start step and then one step per ID, following the link chain
// one node per cycle while the receiver does not stall; an empty flush behaves like a
// search. One item is in work at a time; the next is taken while the last result
// still waits in the output register, and a stalled receiver holds the execute step
// and each flush step until the output register is free, but not the flush start.
module bucketed_id_queues_unit #(
  parameter int CAPACITY    = 64,
  parameter int NUM_BUCKETS = 13,
  parameter int KEY_BASE    = 18,
  parameter int ID_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bidq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bidq_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  bidq_pkg::cmd_t cmd;
  bidq_pkg::sts_t sts;
  logic [6:0]     limit_q;
  logic           cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == bidq_pkg::ADDR_LIMIT);
  assign prdata = (paddr == bidq_pkg::ADDR_LIMIT) ? 32'(limit_q) : '0;

  bidq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bidq_dp #(
    .CAPACITY    (CAPACITY),
    .NUM_BUCKETS (NUM_BUCKETS),
    .KEY_BASE    (KEY_BASE),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[6:0]),
    .limit_q   (limit_q)
  );

endmodule

@@ rtl/core/bidq_checker.sv @@
module bidq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input bidq_pkg::out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != bidq_pkg::ST_OK) |-> out_data.last)
    else $error("error result not final");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != bidq_pkg::ST_OK) |->
      !out_data.found && (out_data.out_id == '0) && (out_data.gap == '0))
    else $error("error result carries data");

  a_gap_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.gap != '0) |-> !out_data.found && out_data.last)
    else $error("gap on non-span result");

endmodule

bind bucketed_id_queues_unit bidq_checker u_bidq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
